// ----- rtl/mlk_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the letter pattern table for the Morse LED keyer.
// No dependencies; every other file but rtl/mlk_checker.sv imports this package.
package mlk_pkg;

	// APB register file geometry
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int TICK_W = 16;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// Register indexes (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_SHORT_ON  = 3'd0,
		REG_LONG_ON   = 3'd1,
		REG_ELEM_GAP  = 3'd2,
		REG_CHAR_GAP  = 3'd3,
		REG_WORD_GAP  = 3'd4
	} reg_idx_t;

	// Register reset values
	localparam logic [TICK_W-1:0] SHORT_ON_RST = 16'd200;
	localparam logic [TICK_W-1:0] LONG_ON_RST  = 16'd700;
	localparam logic [TICK_W-1:0] ELEM_GAP_RST = 16'd100;
	localparam logic [TICK_W-1:0] CHAR_GAP_RST = 16'd300;
	localparam logic [TICK_W-1:0] WORD_GAP_RST = 16'd700;

	// Character codes the front end recognizes
	localparam logic [7:0] CHAR_A     = 8'h61;
	localparam logic [7:0] CHAR_Z     = 8'h7A;
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Item opcodes on the input channel
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic [TICK_W-1:0] short_on;
		logic [TICK_W-1:0] long_on;
		logic [TICK_W-1:0] elem_gap;
		logic [TICK_W-1:0] char_gap;
		logic [TICK_W-1:0] word_gap;
	} cfg_t;

	// Classified request kinds
	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_LETTER = 2'd1,
		CMD_WORD   = 2'd2,
		CMD_OTHER  = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [3:0]  pattern;
		logic [2:0]  left;
	} cmd_t;

	// Player phases
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_ON   = 3'd1,
		PH_EGAP = 3'd2,
		PH_CGAP = 3'd3,
		PH_WORD = 3'd4
	} phase_t;

	// Letter table: length in high nibble, elements (bit 0 first, 1 = dash) low
	function automatic logic [7:0] letter_rom(input logic [4:0] idx);
		logic [7:0] e;
		case (idx)
			5'd0:  e = 8'h22;
			5'd1:  e = 8'h41;
			5'd2:  e = 8'h45;
			5'd3:  e = 8'h31;
			5'd4:  e = 8'h10;
			5'd5:  e = 8'h44;
			5'd6:  e = 8'h33;
			5'd7:  e = 8'h40;
			5'd8:  e = 8'h20;
			5'd9:  e = 8'h4E;
			5'd10: e = 8'h35;
			5'd11: e = 8'h42;
			5'd12: e = 8'h23;
			5'd13: e = 8'h21;
			5'd14: e = 8'h37;
			5'd15: e = 8'h46;
			5'd16: e = 8'h4B;
			5'd17: e = 8'h32;
			5'd18: e = 8'h30;
			5'd19: e = 8'h11;
			5'd20: e = 8'h34;
			5'd21: e = 8'h48;
			5'd22: e = 8'h36;
			5'd23: e = 8'h49;
			5'd24: e = 8'h4D;
			5'd25: e = 8'h43;
			default: e = 8'h00;
		endcase
		return e;
	endfunction

endpackage

// ----- rtl/mlk_regs.sv -----
`timescale 1ns / 1ps
// APB-style register file holding the five timing registers.
// Depends on mlk_pkg.
module mlk_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mlk_pkg::ADDR_W-1:0] paddr,
	input  logic [mlk_pkg::DATA_W-1:0] pwdata,
	output logic [mlk_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output mlk_pkg::cfg_t              cfg
);
	import mlk_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;
	logic [TICK_W-1:0] rd_val;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_on <= SHORT_ON_RST;
			cfg_q.long_on  <= LONG_ON_RST;
			cfg_q.elem_gap <= ELEM_GAP_RST;
			cfg_q.char_gap <= CHAR_GAP_RST;
			cfg_q.word_gap <= WORD_GAP_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SHORT_ON: cfg_q.short_on <= pwdata[TICK_W-1:0];
				REG_LONG_ON:  cfg_q.long_on  <= pwdata[TICK_W-1:0];
				REG_ELEM_GAP: cfg_q.elem_gap <= pwdata[TICK_W-1:0];
				REG_CHAR_GAP: cfg_q.char_gap <= pwdata[TICK_W-1:0];
				REG_WORD_GAP: cfg_q.word_gap <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			REG_SHORT_ON: rd_val = cfg_q.short_on;
			REG_LONG_ON:  rd_val = cfg_q.long_on;
			REG_ELEM_GAP: rd_val = cfg_q.elem_gap;
			REG_CHAR_GAP: rd_val = cfg_q.char_gap;
			REG_WORD_GAP: rd_val = cfg_q.word_gap;
			default:      rd_val = '0;
		endcase
	end

	assign prdata = {{(DATA_W-TICK_W){1'b0}}, rd_val};

endmodule

// ----- rtl/mlk_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input items, classifies them and looks up letter patterns,
// then holds the classified requests in a short queue. Depends on mlk_pkg.
module mlk_front #(
	parameter int QUEUE_DEPTH = mlk_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           op,
	input  logic [7:0]     char_code,
	output logic           cmd_valid,
	output mlk_pkg::cmd_t  cmd,
	input  logic           cmd_pop
);
	import mlk_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	cmd_t             fifo_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	cmd_t             cls;
	logic [7:0]       rom_e;
	logic             push;
	logic             pop;

	// Classify the offered item
	always_comb begin
		rom_e       = letter_rom(5'(char_code - CHAR_A));
		cls.kind    = CMD_OTHER;
		cls.pattern = rom_e[3:0];
		cls.left    = 3'(rom_e[7:4] - 4'd1);
		if (op == OP_TICK) begin
			cls.kind = CMD_TICK;
		end else if (char_code == CHAR_NL || char_code == CHAR_SPACE) begin
			cls.kind = CMD_WORD;
		end else if (char_code >= CHAR_A && char_code <= CHAR_Z) begin
			cls.kind = CMD_LETTER;
		end
	end

	assign in_ready  = (count_q != CNT_FULL);
	assign push      = in_valid & in_ready;
	assign pop       = cmd_pop & cmd_valid;
	assign cmd_valid = (count_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];

	// Store classified requests
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/mlk_back.sv -----
`timescale 1ns / 1ps
// Back end: plays queued requests on the LED state machine and registers one
// result per request. Depends on mlk_pkg.
module mlk_back (
	input  logic           clk,
	input  logic           arst_n,
	input  mlk_pkg::cfg_t  cfg,
	input  logic           cmd_valid,
	input  mlk_pkg::cmd_t  cmd,
	output logic           cmd_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           led,
	output logic           busy_res,
	output logic           accepted
);
	import mlk_pkg::*;

	typedef struct packed {
		phase_t            phase;
		logic [TICK_W-1:0] cnt;
		logic [3:0]        pattern;
		logic [2:0]        left;
	} play_t;

	play_t  st_q;
	play_t  st_d;
	logic   acc_d;
	logic   fire;
	logic   out_valid_q;
	logic   led_q;
	logic   busy_q;
	logic   acc_q;
	logic   led_d;
	logic   busy_d;

	// Char gap after the last element, or idle when it has zero length
	function automatic play_t after_last(input play_t s, input cfg_t c);
		play_t r;
		r = s;
		if (c.char_gap != '0) begin
			r.phase = PH_CGAP;
			r.cnt   = c.char_gap;
		end else begin
			r.phase = PH_IDLE;
			r.cnt   = '0;
		end
		return r;
	endfunction

	// Start the element in bit 0, skipping zero-length phases
	function automatic play_t start_elem(input play_t s, input cfg_t c);
		play_t             r;
		play_t             p;
		logic              done;
		logic [TICK_W-1:0] on_t;
		r    = s;
		p    = s;
		done = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (!done) begin
				on_t = p.pattern[0] ? c.long_on : c.short_on;
				if (on_t != '0) begin
					r       = p;
					r.phase = PH_ON;
					r.cnt   = on_t;
					done    = 1'b1;
				end else if (c.elem_gap != '0) begin
					r       = p;
					r.phase = PH_EGAP;
					r.cnt   = c.elem_gap;
					done    = 1'b1;
				end else if (p.left != '0) begin
					p.pattern = {1'b0, p.pattern[3:1]};
					p.left    = p.left - 1'b1;
				end else begin
					r    = after_last(p, c);
					done = 1'b1;
				end
			end
		end
		if (!done) begin
			r = after_last(p, c);
		end
		return r;
	endfunction

	// Move past the end of an element gap
	function automatic play_t next_elem(input play_t s, input cfg_t c);
		play_t r;
		play_t n;
		n = s;
		if (s.left != '0) begin
			n.pattern = {1'b0, s.pattern[3:1]};
			n.left    = s.left - 1'b1;
			r         = start_elem(n, c);
		end else begin
			r = after_last(s, c);
		end
		return r;
	endfunction

	assign fire    = cmd_valid & (~out_valid_q | out_ready);
	assign cmd_pop = fire;

	// Next state of the player
	always_comb begin
		st_d  = st_q;
		acc_d = 1'b0;
		if (cmd.kind == CMD_TICK) begin
			if (st_q.phase != PH_IDLE) begin
				if (st_q.cnt > 16'd1) begin
					st_d.cnt = st_q.cnt - 1'b1;
				end else begin
					case (st_q.phase)
						PH_ON: begin
							if (cfg.elem_gap != '0) begin
								st_d.phase = PH_EGAP;
								st_d.cnt   = cfg.elem_gap;
							end else begin
								st_d = next_elem(st_q, cfg);
							end
						end
						PH_EGAP: st_d = next_elem(st_q, cfg);
						default: begin
							st_d.phase = PH_IDLE;
							st_d.cnt   = '0;
						end
					endcase
				end
			end
		end else if (st_q.phase == PH_IDLE) begin
			acc_d = 1'b1;
			case (cmd.kind)
				CMD_WORD: begin
					if (cfg.word_gap != '0) begin
						st_d.phase = PH_WORD;
						st_d.cnt   = cfg.word_gap;
					end
				end
				CMD_LETTER: begin
					st_d.pattern = cmd.pattern;
					st_d.left    = cmd.left;
					st_d         = start_elem(st_d, cfg);
				end
				default: ;
			endcase
		end
	end

	// Result fields from the new state
	always_comb begin
		led_d  = (st_d.phase == PH_ON);
		busy_d = (st_d.phase != PH_IDLE);
	end

	// Hold player state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase   <= PH_IDLE;
			st_q.cnt     <= '0;
			st_q.pattern <= '0;
			st_q.left    <= '0;
		end else if (fire) begin
			st_q <= st_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			led_q  <= led_d;
			busy_q <= busy_d;
			acc_q  <= acc_d;
		end
	end

	assign out_valid = out_valid_q;
	assign led       = led_q;
	assign busy_res  = busy_q;
	assign accepted  = acc_q;

endmodule

// ----- rtl/morse_led_keyer.sv -----
`timescale 1ns / 1ps
// Morse LED keyer top level: register file, classifying front end with queue,
// and the playing back end. Depends on mlk_pkg, mlk_regs, mlk_front, mlk_back.
// Throughput: one request per cycle while the output is not stalled.
// The queue of QUEUE_DEPTH entries lets the input run on while the output stalls.
// Reset: asynchronous, active low; registers load their defaults.
module morse_led_keyer #(
	parameter int QUEUE_DEPTH = mlk_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mlk_pkg::ADDR_W-1:0] paddr,
	input  logic [mlk_pkg::DATA_W-1:0] pwdata,
	output logic [mlk_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       op,
	input  logic [7:0]                 char_code,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       led,
	output logic                       busy_res,
	output logic                       accepted
);
	import mlk_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	mlk_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mlk_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.char_code (char_code),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	mlk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.led       (led),
		.busy_res  (busy_res),
		.accepted  (accepted)
	);

endmodule

// ----- rtl/mlk_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the Morse LED keyer, bound to the top level.
// Depends on morse_led_keyer ports only.
module mlk_props (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic led,
	input logic busy_res,
	input logic accepted
);

	logic [7:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;

	// Track requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// A stalled result holds its fields
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(led) && $stable(busy_res)
			&& $stable(accepted))
		else $error("result changed while stalled");

	// A lit LED means something is playing
	a_led_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !led || busy_res)
		else $error("led lit while not busy");

	// No result without a request waiting for it
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 8'd0)
		else $error("result without pending request");

endmodule

bind morse_led_keyer mlk_props u_mlk_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.led       (led),
	.busy_res  (busy_res),
	.accepted  (accepted)
);

// ----- test/mlk_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the Morse LED keyer: follows register writes, predicts
// led / busy_res / accepted per request and compares them. Depends on mlk_pkg.
module mlk_checker
	import mlk_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              op,
	input  logic [7:0]        char_code,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              led,
	input  logic              busy_res,
	input  logic              accepted,
	output int                fail_count,
	output int                pending,
	output logic              playing
);

	typedef struct packed {
		logic led;
		logic busy;
		logic taken;
	} lamp_t;

	// Predicted keyer state and timing registers
	cfg_t        timing;
	phase_t      ph;
	logic [15:0] cnt;
	logic [3:0]  pat;
	logic [2:0]  left;

	lamp_t lamp_due[$];
	int    errs = 0;

	initial begin
		fail_count = 0;
		pending = 0;
		playing = 1'b0;
	end

	// Dots and dashes of each lower-case letter
	function automatic string morse_of(input logic [7:0] ch);
		case (ch)
			"a": return ".-";
			"b": return "-...";
			"c": return "-.-.";
			"d": return "-..";
			"e": return ".";
			"f": return "..-.";
			"g": return "--.";
			"h": return "....";
			"i": return "..";
			"j": return ".---";
			"k": return "-.-";
			"l": return ".-..";
			"m": return "--";
			"n": return "-.";
			"o": return "---";
			"p": return ".--.";
			"q": return "--.-";
			"r": return ".-.";
			"s": return "...";
			"t": return "-";
			"u": return "..-";
			"v": return "...-";
			"w": return ".--";
			"x": return "-..-";
			"y": return "-.--";
			default: return "--..";
		endcase
	endfunction

	// Light the LED for the current element
	function automatic void start_element();
		ph = PH_ON;
		cnt = pat[0] ? timing.long_on : timing.short_on;
	endfunction

	// Move on once the current phase has run out
	function automatic void next_phase();
		case (ph)
			PH_ON: begin
				ph = PH_EGAP;
				cnt = timing.elem_gap;
			end
			PH_EGAP: begin
				if (left != 3'd0) begin
					pat = pat >> 1;
					left = left - 3'd1;
					start_element();
				end else begin
					ph = PH_CGAP;
					cnt = timing.char_gap;
				end
			end
			default: begin
				ph = PH_IDLE;
				cnt = '0;
			end
		endcase
	endfunction

	// Apply one request and return what the keyer should show after it
	function automatic lamp_t play_item(input logic o, input logic [7:0] ch);
		lamp_t r;
		string dits;
		r.taken = 1'b0;
		if (o == OP_TICK) begin
			if (ph != PH_IDLE && cnt != 16'd0)
				cnt = cnt - 16'd1;
		end else if (ph == PH_IDLE) begin
			r.taken = 1'b1;
			if (ch == CHAR_NL || ch == CHAR_SPACE) begin
				ph = PH_WORD;
				cnt = timing.word_gap;
			end else if (ch >= CHAR_A && ch <= CHAR_Z) begin
				dits = morse_of(ch);
				pat = '0;
				for (int i = 0; i < dits.len(); i++)
					pat[i] = (dits[i] == "-");
				left = 3'(dits.len() - 1);
				start_element();
			end
		end
		// skip every phase that has no ticks left
		while (ph != PH_IDLE && cnt == 16'd0)
			next_phase();
		r.led = (ph == PH_ON);
		r.busy = (ph != PH_IDLE);
		return r;
	endfunction

	always @(posedge clk) begin : watch
		lamp_t want;
		if (!arst_n) begin
			timing.short_on = SHORT_ON_RST;
			timing.long_on = LONG_ON_RST;
			timing.elem_gap = ELEM_GAP_RST;
			timing.char_gap = CHAR_GAP_RST;
			timing.word_gap = WORD_GAP_RST;
			ph = PH_IDLE;
			cnt = '0;
			pat = '0;
			left = '0;
			lamp_due.delete();
		end else begin
			// follow register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_SHORT_ON: timing.short_on = pwdata[15:0];
					REG_LONG_ON:  timing.long_on = pwdata[15:0];
					REG_ELEM_GAP: timing.elem_gap = pwdata[15:0];
					REG_CHAR_GAP: timing.char_gap = pwdata[15:0];
					REG_WORD_GAP: timing.word_gap = pwdata[15:0];
					default: ;
				endcase
			end
			// predict each accepted request
			if (in_valid && in_ready)
				lamp_due.push_back(play_item(op, char_code));
			// compare each accepted result with the oldest prediction
			if (out_valid && out_ready) begin
				if (lamp_due.size() == 0) begin
					errs++;
					$error("unexpected result: led=%0b busy_res=%0b accepted=%0b",
						led, busy_res, accepted);
				end else begin
					want = lamp_due.pop_front();
					if (led !== want.led) begin
						errs++;
						$error("led: expected %0b, got %0b", want.led, led);
					end
					if (busy_res !== want.busy) begin
						errs++;
						$error("busy_res: expected %0b, got %0b", want.busy, busy_res);
					end
					if (accepted !== want.taken) begin
						errs++;
						$error("accepted: expected %0b, got %0b", want.taken, accepted);
					end
				end
			end
		end
		fail_count <= errs;
		pending <= lamp_due.size();
		playing <= (ph != PH_IDLE);
	end

endmodule

// ----- test/tb_morse_led_keyer.sv -----
`timescale 1ns / 1ps
// Testbench top for the Morse LED keyer: clock, reset, register writes and
// request / result traffic. Depends on mlk_pkg, morse_led_keyer and mlk_checker.
module tb_morse_led_keyer;
	import mlk_pkg::*;

	localparam int LIMIT = 400000;
	localparam int LONG_HOLD = 300;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              op = 1'b0;
	logic [7:0]        char_code = 8'h00;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              led;
	logic              busy_res;
	logic              accepted;

	int   fail_count;
	int   pending;
	logic playing;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit long_hold_arm = 1'b0;
	bit long_hold_done = 1'b0;
	int hold_left = 0;
	int cycles = 0;

	morse_led_keyer DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .char_code(char_code),
		.out_valid(out_valid), .out_ready(out_ready),
		.led(led), .busy_res(busy_res), .accepted(accepted)
	);

	mlk_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .char_code(char_code),
		.out_valid(out_valid), .out_ready(out_ready),
		.led(led), .busy_res(busy_res), .accepted(accepted),
		.fail_count(fail_count), .pending(pending), .playing(playing)
	);

	always #5 clk = ~clk;

	// Give up after the cycle budget
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Stall the result side at random, plus one long hold-off
	always @(posedge clk) begin
		if (long_hold_arm && !long_hold_done) begin
			long_hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	function automatic cfg_t timing(input logic [15:0] s, input logic [15:0] l,
		input logic [15:0] eg, input logic [15:0] cg, input logic [15:0] wg);
		cfg_t t;
		t.short_on = s;
		t.long_on = l;
		t.elem_gap = eg;
		t.char_gap = cg;
		t.word_gap = wg;
		return t;
	endfunction

	// Mostly short phases, now and then a longer one
	function automatic logic [15:0] pick_ticks(input bit lit);
		logic [15:0] v;
		v = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(4, 12))
			: 16'($urandom_range(0, 3));
		if (lit && v == 16'd0 && $urandom_range(0, 3) != 0)
			v = 16'd1;
		return v;
	endfunction

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return CHAR_A + 8'($urandom_range(0, 25));
			6: return ($urandom_range(0, 1) != 0) ? CHAR_SPACE : CHAR_NL;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Offer one request and hold it until taken
	task automatic push_item(input logic o, input logic [7:0] c);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		char_code <= c;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and wait for every outstanding result
	task automatic wait_quiet();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Setup and access cycle of one register write; psel stays high
	task automatic reg_cycle(input reg_idx_t idx, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0000, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apply_timing(input cfg_t t);
		reg_cycle(REG_SHORT_ON, t.short_on);
		reg_cycle(REG_LONG_ON, t.long_on);
		reg_cycle(REG_ELEM_GAP, t.elem_gap);
		reg_cycle(REG_CHAR_GAP, t.char_gap);
		reg_cycle(REG_WORD_GAP, t.word_gap);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Tick until the keyer has gone quiet
	task automatic drain_player();
		wait_quiet();
		while (playing) begin
			repeat (32) push_item(OP_TICK, 8'($urandom_range(0, 255)));
			wait_quiet();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset timing: idle tick, characters that do nothing, a word gap
		push_item(OP_TICK, 8'h00);
		push_item(OP_CHAR, 8'h00);
		push_item(OP_CHAR, 8'hFF);
		push_item(OP_CHAR, "0");
		push_item(OP_CHAR, "A");
		push_item(OP_CHAR, 8'h60);
		push_item(OP_CHAR, 8'h7B);
		push_item(OP_CHAR, CHAR_SPACE);
		repeat (3) push_item(OP_TICK, 8'hFF);
		push_item(OP_CHAR, "e");
		push_item(OP_CHAR, CHAR_NL);
		drain_player();

		// Shortest timing: zero gaps, one-tick elements
		apply_timing(timing(16'd1, 16'd1, 16'd0, 16'd0, 16'd0));
		push_item(OP_CHAR, CHAR_SPACE);
		push_item(OP_CHAR, CHAR_NL);
		push_item(OP_CHAR, "a");
		repeat (2) push_item(OP_TICK, 8'h00);
		push_item(OP_CHAR, "z");
		push_item(OP_CHAR, "q");
		repeat (4) push_item(OP_TICK, 8'h00);
		push_item(OP_CHAR, "h");
		repeat (4) push_item(OP_TICK, 8'h00);
		drain_player();

		// Zero on-time: the LED never lights
		apply_timing(timing(16'd0, 16'd0, 16'd1, 16'd1, 16'd1));
		push_item(OP_CHAR, "t");
		repeat (2) push_item(OP_TICK, 8'h00);
		push_item(OP_CHAR, "k");
		repeat (5) push_item(OP_TICK, 8'h00);
		drain_player();

		// Random traffic under three idling patterns
		for (int mode = 0; mode < 3; mode++) begin
			tx_idle_pct <= (mode == 0) ? 15 : (mode == 1) ? 84 : 0;
			rx_idle_pct <= (mode == 0) ? 84 : (mode == 1) ? 15 : 0;
			for (int set = 0; set < 2; set++) begin
				wait_quiet();
				apply_timing(timing(pick_ticks(1'b1), pick_ticks(1'b1), pick_ticks(1'b0),
					pick_ticks(1'b0), pick_ticks(1'b0)));
				// hold the result side off while requests keep coming
				if (mode == 2 && set == 0)
					long_hold_arm <= 1'b1;
				for (int n = 0; n < 40; n++) begin
					if (n == 20)
						wait_quiet();
					if ($urandom_range(0, 3) == 0)
						push_item(OP_CHAR, pick_char());
					else
						push_item(OP_TICK, 8'($urandom_range(0, 255)));
				end
			end
		end
		drain_player();

		// Longest timing: load a full-length phase and refuse what follows
		apply_timing(timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		push_item(OP_CHAR, CHAR_SPACE);
		repeat (3) push_item(OP_TICK, 8'h00);
		push_item(OP_CHAR, "x");
		push_item(OP_TICK, 8'h00);

		wait_quiet();
		repeat (5) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- morse_led_keyer.f -----
rtl/mlk_pkg.sv
rtl/mlk_regs.sv
rtl/mlk_front.sv
rtl/mlk_back.sv
rtl/morse_led_keyer.sv
rtl/mlk_checker.sv
test/mlk_checker.sv
test/tb_morse_led_keyer.sv
